### rtl/ipc_block_pool_mailbox_assert.svh
`ifndef IPC_BLOCK_POOL_MAILBOX_ASSERT_SVH
`define IPC_BLOCK_POOL_MAILBOX_ASSERT_SVH

// checks that hold at every clock edge outside reset
`define IBPM_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// checks that hold in the same cycle as their trigger
`define IBPM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/ibpm_pkg.sv
`timescale 1ns / 1ps

package ibpm_pkg;

	typedef enum logic [2:0] {
		CMD_ALLOC   = 3'd0,
		CMD_FREE    = 3'd1,
		CMD_GET_BUF = 3'd2,
		CMD_ENQ     = 3'd3,
		CMD_DEQ     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_PARAM  = 3'd1,
		ST_FULL   = 3'd2,
		ST_ALLOC  = 3'd3,
		ST_EMPTY  = 3'd4,
		ST_FILTER = 3'd5
	} status_t;

	localparam logic CFG_BLOCKS_IN_USE = 1'b0;
	localparam logic CFG_BLOCK_BYTES   = 1'b1;

	localparam int HDR_BYTES = 4;

	localparam logic [4:0]  BLOCKS_IN_USE_RST = 5'd16;
	localparam logic [11:0] BLOCK_BYTES_RST   = 12'd64;

	typedef struct packed {
		status_t     status;
		logic [3:0]  block_out;
		logic [15:0] buffer_offset;
		logic [11:0] size_out;
	} res_t;

endpackage

### rtl/ipc_block_pool_mailbox.sv
`timescale 1ns / 1ps

// channel   direction  handshake                     contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one command word
// m_axis    out        m_axis_tvalid / m_axis_tready  one result word per command
// cfg       in         cfg_we                         pool size and block size
//
// one command word is taken every cycle unless a stalled output holds the pipeline
// a command updates the lock bitmaps and ring pointers and reads the slot memory as it
// leaves the input stage, and the dequeue checks run in the second stage
// reset clears locks and pointers at once; the slot memory needs no clearing pass
// a stalled result parks in the output register while up to two more commands fill behind it

module ipc_block_pool_mailbox
	import ibpm_pkg::*;
#(
	parameter int NUM_CHANNELS = 4,
	parameter int MAX_BLOCKS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // channel[1:0], block[5:2], side[6], filter_accept[7]
	input  logic [2:0]  s_axis_tuser,   // cmd[2:0]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // block_out[3:0], buffer_offset[19:4], size_out[31:20]
	output logic [2:0]  m_axis_tuser,   // status[2:0]

	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_wdata
);

	localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int P_W         = $clog2(MAX_BLOCKS + 1);
	localparam int RING_SLOTS  = MAX_BLOCKS + 1;
	localparam int NUM_FIFOS   = 2 * NUM_CHANNELS;
	localparam int MEM_DEPTH   = NUM_FIFOS * RING_SLOTS;
	localparam int A_W         = $clog2(MEM_DEPTH);

	// configuration
	logic [4:0]  blocks_in_use_q;
	logic [11:0] block_bytes_q;

	// state
	logic [MAX_BLOCKS-1:0] lock_q [NUM_CHANNELS];
	logic [P_W-1:0]        wp_q   [NUM_FIFOS];
	logic [P_W-1:0]        rp_q   [NUM_FIFOS];
	logic [3:0]            slot_mem [MEM_DEPTH];

	// input stage
	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [1:0] channel_s1;
	logic [3:0] block_s1;
	logic       side_s1;
	logic       accept_s1;

	// second stage
	logic                  valid_s2;
	logic                  deq_s2;
	res_t                  res_s2;
	logic [MAX_BLOCKS-1:0] lock_s2;
	logic [3:0]            rdata_s2;

	// output register
	logic out_valid_q;
	res_t out_res_q;

	logic out_ready;
	logic s1_adv;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s1_adv        = !valid_s2 || out_ready;
	assign s_axis_tready = !valid_s1 || s1_adv;

	// stage one combinational signals
	logic [6:0]            bu7;
	logic [P_W-1:0]        pool_n;
	logic                  ch_ok;
	logic [CH_W-1:0]       ch_idx;
	logic                  is_deq;
	logic [CH_W:0]         fifo_idx;
	logic [MAX_BLOCKS-1:0] lock_row;
	logic [MAX_BLOCKS-1:0] lock_shift;
	logic [MAX_BLOCKS-1:0] free_mask;
	logic [MAX_BLOCKS-1:0] grant;
	logic [3:0]            alloc_idx;
	logic                  blk_ok;
	logic                  blk_locked;
	logic [P_W-1:0]        wp;
	logic [P_W-1:0]        rp;
	logic [P_W-1:0]        wp_next;
	logic [P_W-1:0]        rp_next;
	logic [16:0]           prod;
	logic                  do_step;
	res_t                  res_d;
	logic                  deq_d;
	logic                  lock_we;
	logic [MAX_BLOCKS-1:0] lock_d;
	logic                  wp_we;
	logic                  rp_we;
	logic                  mem_we;
	logic                  mem_re;
	logic [A_W-1:0]        mem_addr;

	always_comb begin
		bu7 = 7'(blocks_in_use_q);
		if (bu7 == 7'd0) begin
			pool_n = P_W'(1);
		end else if (bu7 > 7'(MAX_BLOCKS)) begin
			pool_n = P_W'(MAX_BLOCKS);
		end else begin
			pool_n = P_W'(bu7);
		end
	end

	always_comb begin
		ch_ok      = int'(channel_s1) < NUM_CHANNELS;
		ch_idx     = CH_W'(channel_s1);
		is_deq     = cmd_s1 == CMD_DEQ;
		fifo_idx   = {ch_idx, side_s1 ^ is_deq};
		lock_row   = lock_q[ch_idx];
		lock_shift = lock_row >> block_s1;
		blk_locked = lock_shift[0];
		blk_ok     = 8'(block_s1) < 8'(pool_n);
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			free_mask[i] = !lock_row[i] && (8'(i) < 8'(pool_n));
		end
		grant     = free_mask & (~free_mask + MAX_BLOCKS'(1));
		alloc_idx = 4'd0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				alloc_idx = 4'(i);
			end
		end
		wp      = wp_q[fifo_idx];
		rp      = rp_q[fifo_idx];
		wp_next = (wp >= pool_n) ? '0 : wp + P_W'(1);
		rp_next = (rp >= pool_n) ? '0 : rp + P_W'(1);
		prod    = 17'(block_s1) * (17'(block_bytes_q) + 17'(HDR_BYTES));
	end

	always_comb begin
		do_step  = valid_s1 && s1_adv;
		res_d    = '{status: ST_PARAM, block_out: 4'd0, buffer_offset: 16'd0, size_out: 12'd0};
		deq_d    = 1'b0;
		lock_we  = 1'b0;
		lock_d   = lock_row;
		wp_we    = 1'b0;
		rp_we    = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = A_W'(fifo_idx) * A_W'(RING_SLOTS) + A_W'(is_deq ? rp : wp);
		if (ch_ok) begin
			case (cmd_s1)
				CMD_ALLOC: begin
					if (free_mask == '0) begin
						res_d.status = ST_FULL;
					end else begin
						res_d.status    = ST_OK;
						res_d.block_out = alloc_idx;
						lock_we         = 1'b1;
						lock_d          = lock_row | grant;
					end
				end
				CMD_DEQ: begin
					if (wp == rp) begin
						res_d.status = ST_EMPTY;
					end else begin
						deq_d  = 1'b1;
						rp_we  = 1'b1;
						mem_re = 1'b1;
					end
				end
				CMD_FREE: begin
					if (!blk_ok) begin
						res_d.status = ST_PARAM;
					end else if (!blk_locked) begin
						res_d.status = ST_ALLOC;
					end else begin
						res_d.status = ST_OK;
						lock_we      = 1'b1;
						lock_d       = lock_row & ~(MAX_BLOCKS'(1) << block_s1);
					end
				end
				CMD_GET_BUF: begin
					if (!blk_ok) begin
						res_d.status = ST_PARAM;
					end else if (!blk_locked) begin
						res_d.status = ST_ALLOC;
					end else begin
						res_d.status        = ST_OK;
						res_d.buffer_offset = 16'(prod + 17'(HDR_BYTES));
						res_d.size_out      = block_bytes_q;
					end
				end
				CMD_ENQ: begin
					if (!blk_ok) begin
						res_d.status = ST_PARAM;
					end else if (!accept_s1) begin
						res_d.status = ST_FILTER;
					end else if (!blk_locked) begin
						res_d.status = ST_ALLOC;
					end else if (wp_next == rp) begin
						res_d.status = ST_FULL;
					end else begin
						res_d.status = ST_OK;
						wp_we        = 1'b1;
						mem_we       = 1'b1;
					end
				end
				default: begin
					res_d.status = ST_PARAM;
				end
			endcase
		end
	end

	// dequeue checks on the slot read back from memory
	res_t            res_fin;
	logic [MAX_BLOCKS-1:0] deq_shift;

	always_comb begin
		res_fin   = res_s2;
		deq_shift = lock_s2 >> rdata_s2;
		if (deq_s2) begin
			res_fin.block_out = rdata_s2;
			if (8'(rdata_s2) >= 8'(pool_n)) begin
				res_fin.status = ST_PARAM;
			end else if (!deq_shift[0]) begin
				res_fin.status = ST_ALLOC;
			end else begin
				res_fin.status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
			block_bytes_q   <= BLOCK_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata[4:0];
				CFG_BLOCK_BYTES:   block_bytes_q   <= cfg_wdata;
				default:           block_bytes_q   <= block_bytes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				lock_q[c] <= '0;
			end
			for (int f = 0; f < NUM_FIFOS; f++) begin
				wp_q[f] <= '0;
				rp_q[f] <= '0;
			end
		end else if (do_step) begin
			if (lock_we) begin
				lock_q[ch_idx] <= lock_d;
			end
			if (wp_we) begin
				wp_q[fifo_idx] <= wp_next;
			end
			if (rp_we) begin
				rp_q[fifo_idx] <= rp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && mem_we) begin
			slot_mem[mem_addr] <= block_s1;
		end
		if (do_step && mem_re) begin
			rdata_s2 <= slot_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s1_adv) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1     <= s_axis_tuser;
			channel_s1 <= s_axis_tdata[1:0];
			block_s1   <= s_axis_tdata[5:2];
			side_s1    <= s_axis_tdata[6];
			accept_s1  <= s_axis_tdata[7];
		end
		if (do_step) begin
			res_s2  <= res_d;
			deq_s2  <= deq_d;
			lock_s2 <= lock_row;
		end
		if (out_ready && valid_s2) begin
			out_res_q <= res_fin;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_res_q.size_out, out_res_q.buffer_offset, out_res_q.block_out};
	assign m_axis_tuser  = out_res_q.status;

`include "ipc_block_pool_mailbox_assert.svh"

	`IBPM_ASSERT_IMPLY(a_grant_onehot, valid_s1, $onehot0(grant), "alloc grant not one-hot")
	`IBPM_ASSERT_ALWAYS(a_mem_one_port, !(mem_we && mem_re), "slot memory read and write together")
	`IBPM_ASSERT_IMPLY(a_stall_full, !s_axis_tready, valid_s1 && valid_s2 && out_valid_q,
		"input stalled with a free stage")

endmodule
